// ===== rtl/core/sbus_frame_decoder_core_macros.svh =====
// ----------------------------------------------------------------------------
// sbus_frame_decoder_core_macros.svh
// Assertion helpers used by the channel unpacker of the frame decoder.
// ----------------------------------------------------------------------------
`ifndef SBUS_FRAME_DECODER_CORE_MACROS_SVH
`define SBUS_FRAME_DECODER_CORE_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define SFD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("sfd assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define SFD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("sfd assertion failed");

`endif

// ===== rtl/core/sfd_pkg.sv =====
// ----------------------------------------------------------------------------
// sfd_pkg
// Types and constants of the serial frame decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sfd_pkg;

    localparam int PAYLOAD_BYTES = 23;
    localparam int DATA_BYTES    = PAYLOAD_BYTES - 1;
    localparam int CHANNELS      = 16;
    localparam int CH_BITS       = 11;
    localparam int DATA_BITS     = DATA_BYTES * 8;
    localparam int CNT_W         = 5;
    localparam int CH_IDX_W      = 4;

    localparam logic [CNT_W-1:0]    FLAGS_IDX = CNT_W'(DATA_BYTES);
    localparam logic [CH_IDX_W-1:0] LAST_CH   = CH_IDX_W'(CHANNELS - 1);

    // Configuration register indexes.
    localparam logic [1:0] REG_HEADER    = 2'd0;
    localparam logic [1:0] REG_FOOTER    = 2'd1;
    localparam logic [1:0] REG_LOST_MASK = 2'd2;
    localparam logic [1:0] REG_FAIL_MASK = 2'd3;

    // Reset values of the configuration registers.
    localparam logic [7:0] RST_HEADER    = 8'h0F;
    localparam logic [7:0] RST_FOOTER    = 8'h00;
    localparam logic [7:0] RST_LOST_MASK = 8'h04;
    localparam logic [7:0] RST_FAIL_MASK = 8'h08;

    typedef enum logic [2:0] {
        PH_HUNT    = 3'b001,
        PH_COLLECT = 3'b010,
        PH_FOOTER  = 3'b100
    } t_phase;

    // Per-transaction control from the frame tracker to the unpacker.
    typedef struct packed {
        logic       shift_en;
        logic       frame_done;
        logic       link_lost;
        logic       failsafe;
        logic [7:0] data_byte;
    } t_frame_ctl;

endpackage

// ===== rtl/core/sfd_frame_tracker.sv =====
// ----------------------------------------------------------------------------
// sfd_frame_tracker
// Header/footer hunt and payload byte counting for each received byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sfd_frame_tracker
    import sfd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_byte,
    input  logic [7:0] i_header,
    input  logic [7:0] i_footer,
    input  logic [7:0] i_lost_mask,
    input  logic [7:0] i_fail_mask,
    output t_frame_ctl o_ctl
);

    t_phase           r_phase, n_phase;
    logic [CNT_W-1:0] r_count, n_count;
    logic [7:0]       r_prev;
    logic             collecting;

    assign collecting = (r_phase == PH_COLLECT);

    always_comb begin
        o_ctl.shift_en   = i_accept && collecting && (r_count < FLAGS_IDX);
        o_ctl.frame_done = i_accept && collecting && (r_count == FLAGS_IDX);
        o_ctl.link_lost  = |(i_byte & i_lost_mask);
        o_ctl.failsafe   = |(i_byte & i_fail_mask);
        o_ctl.data_byte  = i_byte;
    end

    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        unique case (r_phase)
            PH_COLLECT: begin
                n_count = r_count + CNT_W'(1);
                if (r_count == FLAGS_IDX) begin
                    n_phase = PH_FOOTER;
                end
            end
            PH_FOOTER: begin
                if (i_byte == i_footer) begin
                    n_phase = PH_HUNT;
                    n_count = '0;
                end
            end
            default: begin
                if (i_byte == i_header && r_prev == i_footer) begin
                    n_phase = PH_COLLECT;
                    n_count = '0;
                end else begin
                    n_phase = PH_HUNT;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_count <= '0;
            r_prev  <= RST_FOOTER;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_prev  <= i_byte;
        end
    end

endmodule

// ===== rtl/core/sfd_channel_unpacker.sv =====
// ----------------------------------------------------------------------------
// sfd_channel_unpacker
// Byte-serial payload shift line that drains one 11-bit channel per cycle while i_ch_ready is high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sbus_frame_decoder_core_macros.svh"

module sfd_channel_unpacker
    import sfd_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_frame_ctl          i_ctl,
    output logic                o_busy,
    output logic                o_ch_valid,
    input  logic                i_ch_ready,
    output logic [CH_IDX_W-1:0] o_channel_index,
    output logic [CH_BITS-1:0]  o_channel_value,
    output logic                o_link_lost,
    output logic                o_failsafe,
    output logic                o_last_channel
);

    logic [DATA_BITS-1:0] r_bits;
    logic [CH_IDX_W-1:0]  r_cnt;
    logic                 r_busy;
    logic                 r_lost;
    logic                 r_fail;
    logic                 out_take;

    assign out_take = r_busy && i_ch_ready;

    // Bytes enter at the top, so byte 0 ends up in the low bits; channels
    // then leave from the low end, eleven bits at a time.
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift_en) begin
            r_bits <= {i_ctl.data_byte, r_bits[DATA_BITS-1:8]};
        end else if (out_take) begin
            r_bits <= {CH_BITS'(0), r_bits[DATA_BITS-1:CH_BITS]};
        end
        if (i_ctl.frame_done) begin
            r_lost <= i_ctl.link_lost;
            r_fail <= i_ctl.failsafe;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_ctl.frame_done) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (out_take) begin
            r_cnt <= r_cnt + CH_IDX_W'(1);
            if (r_cnt == LAST_CH) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy          = r_busy;
    assign o_ch_valid      = r_busy;
    assign o_channel_index = r_cnt;
    assign o_channel_value = r_bits[CH_BITS-1:0];
    assign o_link_lost     = r_lost;
    assign o_failsafe      = r_fail;
    assign o_last_channel  = (r_cnt == LAST_CH);

    `SFD_ASSERT_NOW(a_no_load_while_busy, r_busy, !i_ctl.shift_en && !i_ctl.frame_done)
    `SFD_ASSERT_NEXT(a_last_ends_frame, out_take && o_last_channel, !r_busy)
    `SFD_ASSERT_NOW(a_frame_starts_at_zero, $rose(r_busy), r_cnt == '0)

endmodule

// ===== rtl/core/sbus_frame_decoder_core.sv =====
// The result for channel 0 is valid the cycle after the last payload (flags) byte is taken.
// The input takes one byte per cycle while idle; after a frame's flags byte it stalls
// while the 16 channel results drain, one per cycle while i_ch_ready is high.
// Reset (synchronous, active low) clears the frame state and restores register defaults.
// ----------------------------------------------------------------------------
// sbus_frame_decoder_core
// Byte-serial frame decoder that unpacks sixteen 11-bit channels per frame.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sbus_frame_decoder_core
    import sfd_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Configuration write port.
    input  logic                i_cfg_wr_en,
    input  logic [1:0]          i_cfg_addr,
    input  logic [7:0]          i_cfg_wdata,
    // Received byte channel.
    input  logic                i_rx_valid,
    output logic                o_rx_ready,
    input  logic [7:0]          i_rx_byte,
    // Channel result channel.
    output logic                o_ch_valid,
    input  logic                i_ch_ready,
    output logic [CH_IDX_W-1:0] o_channel_index,
    output logic [CH_BITS-1:0]  o_channel_value,
    output logic                o_link_lost,
    output logic                o_failsafe,
    output logic                o_last_channel
);

    // Configuration registers. They are only to be written while the decoder is idle,
    // so no shadowing is needed; the user is bound by this, the block does not enforce it.
    logic [7:0] r_header;
    logic [7:0] r_footer;
    logic [7:0] r_lost_mask;
    logic [7:0] r_fail_mask;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header    <= RST_HEADER;
            r_footer    <= RST_FOOTER;
            r_lost_mask <= RST_LOST_MASK;
            r_fail_mask <= RST_FAIL_MASK;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                REG_HEADER:    r_header    <= i_cfg_wdata;
                REG_FOOTER:    r_footer    <= i_cfg_wdata;
                REG_LOST_MASK: r_lost_mask <= i_cfg_wdata;
                REG_FAIL_MASK: r_fail_mask <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // A byte transaction is taken whenever the unpacker is not draining a
    // frame. Every taken byte updates the tracker; data bytes are shifted
    // into the unpacker and the flags byte starts the channel drain.
    logic       busy;
    logic       rx_accept;
    t_frame_ctl frame_ctl;

    assign o_rx_ready = !busy;
    assign rx_accept  = i_rx_valid && !busy;

    sfd_frame_tracker u_tracker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (rx_accept),
        .i_byte      (i_rx_byte),
        .i_header    (r_header),
        .i_footer    (r_footer),
        .i_lost_mask (r_lost_mask),
        .i_fail_mask (r_fail_mask),
        .o_ctl       (frame_ctl)
    );

    // The unpacker holds each channel result in registers until its
    // transaction completes, then shifts the next eleven bits down.
    sfd_channel_unpacker u_unpacker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (frame_ctl),
        .o_busy          (busy),
        .o_ch_valid      (o_ch_valid),
        .i_ch_ready      (i_ch_ready),
        .o_channel_index (o_channel_index),
        .o_channel_value (o_channel_value),
        .o_link_lost     (o_link_lost),
        .o_failsafe      (o_failsafe),
        .o_last_channel  (o_last_channel)
    );

endmodule
